@@ rtl/core/scv_pkg.sv @@
// ----------------------------------------------------------------------------
// scv_pkg
// Shared types, constants and the CRC-8 lookup table of the image validator.
// ----------------------------------------------------------------------------
`default_nettype none

package scv_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;

  localparam logic [ByteW-1:0] CrcInit = 8'hFF;
  localparam logic [ByteW-1:0] RevLow  = 8'd8;
  localparam logic [ByteW-1:0] RevHigh = 8'd9;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_CRC_BAD = 2'd1,
    ST_REV_BAD = 2'd2
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [ByteW-1:0] crc;
    logic [ByteW-1:0] revision;
  } result_t;

  localparam logic [ByteW-1:0] CrcLut [256] = '{
    8'h00, 8'hF7, 8'hB9, 8'h4E, 8'h25, 8'hD2, 8'h9C, 8'h6B,
    8'h4A, 8'hBD, 8'hF3, 8'h04, 8'h6F, 8'h98, 8'hD6, 8'h21,
    8'h94, 8'h63, 8'h2D, 8'hDA, 8'hB1, 8'h46, 8'h08, 8'hFF,
    8'hDE, 8'h29, 8'h67, 8'h90, 8'hFB, 8'h0C, 8'h42, 8'hB5,
    8'h7F, 8'h88, 8'hC6, 8'h31, 8'h5A, 8'hAD, 8'hE3, 8'h14,
    8'h35, 8'hC2, 8'h8C, 8'h7B, 8'h10, 8'hE7, 8'hA9, 8'h5E,
    8'hEB, 8'h1C, 8'h52, 8'hA5, 8'hCE, 8'h39, 8'h77, 8'h80,
    8'hA1, 8'h56, 8'h18, 8'hEF, 8'h84, 8'h73, 8'h3D, 8'hCA,
    8'hFE, 8'h09, 8'h47, 8'hB0, 8'hDB, 8'h2C, 8'h62, 8'h95,
    8'hB4, 8'h43, 8'h0D, 8'hFA, 8'h91, 8'h66, 8'h28, 8'hDF,
    8'h6A, 8'h9D, 8'hD3, 8'h24, 8'h4F, 8'hB8, 8'hF6, 8'h01,
    8'h20, 8'hD7, 8'h99, 8'h6E, 8'h05, 8'hF2, 8'hBC, 8'h4B,
    8'h81, 8'h76, 8'h38, 8'hCF, 8'hA4, 8'h53, 8'h1D, 8'hEA,
    8'hCB, 8'h3C, 8'h72, 8'h85, 8'hEE, 8'h19, 8'h57, 8'hA0,
    8'h15, 8'hE2, 8'hAC, 8'h5B, 8'h30, 8'hC7, 8'h89, 8'h7E,
    8'h5F, 8'hA8, 8'hE6, 8'h11, 8'h7A, 8'h8D, 8'hC3, 8'h34,
    8'hAB, 8'h5C, 8'h12, 8'hE5, 8'h8E, 8'h79, 8'h37, 8'hC0,
    8'hE1, 8'h16, 8'h58, 8'hAF, 8'hC4, 8'h33, 8'h7D, 8'h8A,
    8'h3F, 8'hC8, 8'h86, 8'h71, 8'h1A, 8'hED, 8'hA3, 8'h54,
    8'h75, 8'h82, 8'hCC, 8'h3B, 8'h50, 8'hA7, 8'hE9, 8'h1E,
    8'hD4, 8'h23, 8'h6D, 8'h9A, 8'hF1, 8'h06, 8'h48, 8'hBF,
    8'h9E, 8'h69, 8'h27, 8'hD0, 8'hBB, 8'h4C, 8'h02, 8'hF5,
    8'h40, 8'hB7, 8'hF9, 8'h0E, 8'h65, 8'h92, 8'hDC, 8'h2B,
    8'h0A, 8'hFD, 8'hB3, 8'h44, 8'h2F, 8'hD8, 8'h96, 8'h61,
    8'h55, 8'hA2, 8'hEC, 8'h1B, 8'h70, 8'h87, 8'hC9, 8'h3E,
    8'h1F, 8'hE8, 8'hA6, 8'h51, 8'h3A, 8'hCD, 8'h83, 8'h74,
    8'hC1, 8'h36, 8'h78, 8'h8F, 8'hE4, 8'h13, 8'h5D, 8'hAA,
    8'h8B, 8'h7C, 8'h32, 8'hC5, 8'hAE, 8'h59, 8'h17, 8'hE0,
    8'h2A, 8'hDD, 8'h93, 8'h64, 8'h0F, 8'hF8, 8'hB6, 8'h41,
    8'h60, 8'h97, 8'hD9, 8'h2E, 8'h45, 8'hB2, 8'hFC, 8'h0B,
    8'hBE, 8'h49, 8'h07, 8'hF0, 8'h9B, 8'h6C, 8'h22, 8'hD5,
    8'hF4, 8'h03, 8'h4D, 8'hBA, 8'hD1, 8'h26, 8'h68, 8'h9F
  };

endpackage

`default_nettype wire

@@ rtl/core/scv_fold.sv @@
// ----------------------------------------------------------------------------
// scv_fold
// Folds one image word into the running CRC-8, or only the low byte of a final
// word, and builds the check result for a final word.
// ----------------------------------------------------------------------------
`default_nettype none

module scv_fold (
  input  wire logic [scv_pkg::ByteW-1:0] crc_i,
  input  wire logic [scv_pkg::WordW-1:0] word_i,
  input  wire logic                      last_i,
  output logic      [scv_pkg::ByteW-1:0] next_crc_o,
  output scv_pkg::result_t               res_o
);

  logic [scv_pkg::ByteW-1:0] lo;
  logic [scv_pkg::ByteW-1:0] hi;
  logic [scv_pkg::ByteW-1:0] crc_lo;
  logic [scv_pkg::ByteW-1:0] crc_hi;
  logic [scv_pkg::ByteW-1:0] crc_fin;
  logic                      rev_ok;

  assign lo      = word_i[scv_pkg::ByteW-1:0];
  assign hi      = word_i[scv_pkg::WordW-1:scv_pkg::ByteW];
  assign crc_lo  = scv_pkg::CrcLut[crc_i ^ lo];
  assign crc_hi  = scv_pkg::CrcLut[crc_lo ^ hi];
  assign crc_fin = crc_lo ^ scv_pkg::CrcInit;
  assign rev_ok  = (lo == scv_pkg::RevLow) || (lo == scv_pkg::RevHigh);

  assign next_crc_o = last_i ? scv_pkg::CrcInit : crc_hi;

  always_comb begin
    res_o.crc      = crc_fin;
    res_o.revision = lo;
    priority if (crc_fin != hi) begin
      res_o.status = scv_pkg::ST_CRC_BAD;
    end else if (!rev_ok) begin
      res_o.status = scv_pkg::ST_REV_BAD;
    end else begin
      res_o.status = scv_pkg::ST_VALID;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sprom_crc8_validator.sv @@
// ----------------------------------------------------------------------------
// sprom_crc8_validator
// CRC-8 check of a configuration image streamed as 16-bit words.
// ----------------------------------------------------------------------------
// One image word is taken per clock cycle, without gaps, as long as the result
// side keeps up. Each word passes an input register, then two chained 256-entry
// table lookups fold its low and high byte into the running CRC. A final word
// folds only its low byte; its high byte is the expected CRC. Only the final word
// of an image produces a transfer on the result side, via the input register and
// then the output register; the result waits there while words keep flowing,
// up to the next final word. The CRC returns to 0xFF after each final word.
`default_nettype none

module sprom_crc8_validator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] image_word_i,
  input  wire logic        last_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [1:0]  status_o,
  output logic      [7:0]  computed_crc_o,
  output logic      [7:0]  revision_o
);

  logic                      in_valid_d, in_valid_q;
  logic [scv_pkg::WordW-1:0] word_q;
  logic                      last_q;
  logic [scv_pkg::ByteW-1:0] crc_d, crc_q;
  logic                      out_valid_d, out_valid_q;
  scv_pkg::result_t          res_q;

  logic                      in_xfer;
  logic                      out_free;
  logic                      advance;
  logic                      emit;
  logic [scv_pkg::ByteW-1:0] next_crc;
  scv_pkg::result_t          res;

  scv_fold u_fold (
    .crc_i      (crc_q),
    .word_i     (word_q),
    .last_i     (last_q),
    .next_crc_o (next_crc),
    .res_o      (res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!last_q || out_free);
  assign emit       = advance && last_q;
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_xfer || (in_valid_q && !advance);
  assign crc_d       = advance ? next_crc : crc_q;
  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      crc_q       <= scv_pkg::CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      word_q <= image_word_i;
      last_q <= last_word_i;
    end
    if (emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign computed_crc_o = res_q.crc;
  assign revision_o     = res_q.revision;

`ifndef ASSERT_OFF
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && last_q && out_valid_q)
    else $error("input stalled without a held final word");

  a_crc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> crc_q == scv_pkg::CrcInit)
    else $error("running CRC not restarted after final word");

  a_no_code3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == scv_pkg::ST_VALID || status_o == scv_pkg::ST_CRC_BAD ||
      status_o == scv_pkg::ST_REV_BAD)
    else $error("undefined status code");

  a_valid_rev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == scv_pkg::ST_VALID |->
      revision_o == scv_pkg::RevLow || revision_o == scv_pkg::RevHigh)
    else $error("valid status with unsupported revision");
`endif

endmodule

`default_nettype wire
